[rtl/fdrt_pkg.sv]
// Shared types and constants for the reciprocal-table divider.
`default_nettype none
package fdrt_pkg;
    localparam int TableDepthDef = 1024;
    localparam int TableWidth    = 36;
    localparam int SlopeWidth    = 13;
    localparam int FracWidth     = 23;
    localparam logic [7:0] ExpBiasAdj = 8'd126;

    typedef enum logic
    {
        OP_WRITE  = 1'b0,
        OP_DIVIDE = 1'b1
    } opcode_t;

    // Operand fields carried along the pipe
    typedef struct packed
    {
        logic        sign;
        logic [7:0]  exp;
        logic        zero;
        logic [23:0] xm;
    } ctl_t;
endpackage
`default_nettype wire

[rtl/fdrt_recip.sv]
// Reciprocal table storage and interpolated reciprocal mantissa, two stages.
`default_nettype none
module fdrt_recip #(
    parameter int TABLE_DEPTH = fdrt_pkg::TableDepthDef
) (
    input  wire logic                         clk,
    input  wire logic                         adv,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
    input  wire logic [fdrt_pkg::TableWidth-1:0] wr_data,
    input  wire logic                         rd_en,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
    input  wire logic [fdrt_pkg::SlopeWidth-1:0] offset,
    output logic [fdrt_pkg::FracWidth:0]        ym
);
    import fdrt_pkg::*;

    logic [TableWidth-1:0] mem [TABLE_DEPTH];
    logic [TableWidth-1:0] word_reg;
    logic [SlopeWidth-1:0] off_reg;
    logic [TableWidth-1:0] diff_next;
    logic [FracWidth-1:0]  frac_reg;

    // Write table words, read one word per advancing beat with rd_en set
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (adv && rd_en)
        begin
            word_reg <= mem[rd_addr];
        end
        if (adv)
        begin
            off_reg  <= offset;
            frac_reg <= diff_next[TableWidth-1:SlopeWidth];
        end
    end

    // Interpolate: base minus twice offset times slope, modulo 2^36
    always_comb
    begin
        diff_next = {word_reg[TableWidth-1:SlopeWidth], {SlopeWidth{1'b0}}}
                  - {9'd0, 26'(off_reg) * 26'(word_reg[SlopeWidth-1:0]), 1'b0};
    end

    assign ym = {1'b1, frac_reg};
endmodule
`default_nettype wire

[rtl/fdrt_mul.sv]
// Mantissa multiply and normalize, two stages.
`default_nettype none
module fdrt_mul (
    input  wire logic             clk,
    input  wire logic             adv,
    input  wire fdrt_pkg::ctl_t   ctl,
    input  wire logic [23:0]      ym,
    output logic [31:0]           quotient
);
    import fdrt_pkg::*;

    logic [47:0] prod_reg;
    ctl_t        ctl_reg;
    logic [31:0] q_reg;
    logic [22:0] m;
    logic [7:0]  e;

    // Register the product, then the normalized quotient
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= ctl.xm * ym;
            ctl_reg  <= ctl;
            q_reg    <= ctl_reg.zero ? 32'd0 : {ctl_reg.sign, e, m};
        end
    end

    always_comb
    begin
        if (prod_reg[47])
        begin
            m = prod_reg[46:24];
            e = ctl_reg.exp + 8'd1;
        end
        else
        begin
            m = prod_reg[45:23];
            e = ctl_reg.exp;
        end
    end

    assign quotient = q_reg;
endmodule
`default_nettype wire

[rtl/float32_divide_reciprocal_table.sv]
// Top level of the pipelined reciprocal-table divider.
// One beat enters per cycle unless the pipe stalls. A divide beat yields
// its quotient after table read, interpolation, multiply and normalize; a
// table write beat yields nothing. The output stage holds a result under
// backpressure; the whole pipe stalls only when that stage is full and not
// drained. A table entry must be written before a divide reads it.
`default_nettype none
module float32_divide_reciprocal_table #(
    parameter int TABLE_DEPTH = fdrt_pkg::TableDepthDef
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // dividend[31:0], divisor[63:32], entry_index[73:64],
    // entry_word[109:74], zero fill [111:110]
    input  wire logic [111:0] s_tdata,
    // opcode[0]
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // quotient[31:0]
    output logic [31:0]       m_tdata
);
    import fdrt_pkg::*;
    localparam int AW = $clog2(TABLE_DEPTH);

    logic        adv, acc, is_div;
    logic [31:0] x, y;
    logic [3:0]  v_reg;
    ctl_t        c0_reg, c1_reg, c_next;
    logic [23:0] ym;
    logic [31:0] q;
    logic [7:0]  xe, ye;

    assign x      = s_tdata[31:0];
    assign y      = s_tdata[63:32];
    assign adv    = !v_reg[3] || m_tready;
    assign s_tready = adv;
    assign acc    = s_tvalid && adv;
    assign is_div = (opcode_t'(s_tuser) == OP_DIVIDE);
    assign xe     = x[30:23];
    assign ye     = y[30:23];

    // Decode the operand fields
    always_comb
    begin
        c_next.sign = x[31] ^ y[31];
        c_next.exp  = xe + ExpBiasAdj - ye;
        c_next.zero = (xe == 8'd0);
        c_next.xm   = {1'b1, x[22:0]};
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[2:0], acc && is_div};
        end
    end

    // Carry operand fields alongside the table stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c0_reg <= c_next;
            c1_reg <= c0_reg;
        end
    end

    fdrt_recip #(.TABLE_DEPTH(TABLE_DEPTH)) u_recip (
        .clk     (clk),
        .adv     (adv),
        .wr_en   (acc && !is_div),
        .wr_addr (s_tdata[64 +: AW]),
        .wr_data (s_tdata[109:74]),
        .rd_en   (acc && is_div),
        .rd_addr (y[13 +: AW]),
        .offset  (y[12:0]),
        .ym      (ym)
    );

    fdrt_mul u_mul (
        .clk      (clk),
        .adv      (adv),
        .ctl      (c1_reg),
        .ym       (ym),
        .quotient (q)
    );

    assign m_tvalid = v_reg[3];
    assign m_tdata  = q;
endmodule
`default_nettype wire
